@@ hdl/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helpers for the NMEA sentence checksum
// framer.
// ----------------------------------------------------------------------------
package nsc_pkg;

    // Default maximum line length, in bytes
    localparam int LINE_LIMIT_DEF = 128;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Sentence names after the '$'; entry k holds name k, first char in MSB byte
    localparam logic [3:0][4:0][7:0] KIND_NAMES = {"GPTXT", "GNGSA", "BDGSV", "GPGSV"};

    // Positions within the line: first and last name character, then done and saturated
    localparam logic [2:0] NAME_POS_FIRST = 3'd1;
    localparam logic [2:0] NAME_POS_LAST  = 3'd5;
    localparam logic [2:0] NAME_POS_DONE  = 3'd6;
    localparam logic [2:0] NAME_POS_SAT   = 3'd7;

    typedef enum logic [1:0] {
        ST_NO_DOLLAR = 2'd0,
        ST_BAD_SUM   = 2'd1,
        ST_ACCEPTED  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_GPGSV = 3'd1,
        KIND_BDGSV = 3'd2,
        KIND_GNGSA = 3'd3,
        KIND_GPTXT = 3'd4
    } t_kind;

    // One result transaction
    typedef struct packed {
        t_status     line_status;
        t_kind       sentence_kind;
        logic [7:0]  computed_checksum;
        logic [7:0]  received_checksum;
        logic [31:0] accepted_total;
        logic [31:0] checksum_error_total;
    } t_result;

    // Hex digit decode: bit 4 = valid, bits 3..0 = value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= "0" && c <= "9") begin
            d = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            d = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            d = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return d;
    endfunction

    // Expected character of name k at line position pos (1..5)
    function automatic logic [7:0] name_char(input logic [1:0] k, input logic [2:0] pos);
        logic [2:0] idx;
        idx = 3'd5 - pos;
        return KIND_NAMES[k][idx];
    endfunction

endpackage

@@ hdl/nsc_line_tracker.sv @@
// ----------------------------------------------------------------------------
// nsc_line_tracker
// Per-line state registers: checksum, hex digits after '*', sentence name
// match and counters. Produces a result on a line feed ending a non-empty line.
// ----------------------------------------------------------------------------
module nsc_line_tracker #(
    parameter int LINE_LIMIT = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output nsc_pkg::t_result o_res
);
    import nsc_pkg::*;

    localparam int LEN_W = $clog2(LINE_LIMIT);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_LIMIT - 1);

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_dollar, n_dollar;
    logic             r_star, n_star;
    logic [7:0]       r_sum, n_sum;
    logic [1:0]       r_cas, n_cas;
    logic [4:0]       r_hex1, n_hex1;
    logic [4:0]       r_hex2, n_hex2;
    logic [2:0]       r_pos, n_pos;
    logic [3:0]       r_flags, n_flags;
    logic             r_closed, n_closed;
    logic [31:0]      r_acc, n_acc;
    logic [31:0]      r_err, n_err;

    logic [LEN_W-1:0] eff_len;
    logic [7:0]       recv;
    t_result          res;
    logic             res_valid;

    // Next-state and result logic for one byte
    always_comb begin
        n_len    = r_len;
        n_dollar = r_dollar;
        n_star   = r_star;
        n_sum    = r_sum;
        n_cas    = r_cas;
        n_hex1   = r_hex1;
        n_hex2   = r_hex2;
        n_pos    = r_pos;
        n_flags  = r_flags;
        n_closed = r_closed;
        n_acc    = r_acc;
        n_err    = r_err;
        res_valid = 1'b0;
        recv     = 8'd0;
        eff_len  = (i_byte == CH_DOLLAR) ? '0 : r_len;

        res.line_status          = ST_NO_DOLLAR;
        res.sentence_kind        = KIND_OTHER;
        res.computed_checksum    = 8'd0;
        res.received_checksum    = 8'd0;
        res.accepted_total       = r_acc;
        res.checksum_error_total = r_err;

        if (i_byte == CH_CR) begin
            // carriage return ignored
        end else if (i_byte == CH_LF) begin
            if (r_len != '0) begin
                res_valid = 1'b1;
                n_len     = '0;
                if (r_dollar) begin
                    res.computed_checksum = r_sum;
                    if (r_star && r_cas == 2'd2) begin
                        if (r_hex1[4]) begin
                            recv = r_hex2[4] ? {r_hex1[3:0], r_hex2[3:0]}
                                             : {4'd0, r_hex1[3:0]};
                        end
                        res.received_checksum = recv;
                        if (recv == r_sum) begin
                            res.line_status = ST_ACCEPTED;
                            n_acc = r_acc + 32'd1;
                            if (r_pos == NAME_POS_DONE) begin
                                for (int k = 3; k >= 0; k--) begin
                                    if (r_flags[k]) begin
                                        res.sentence_kind = t_kind'(3'(k + 1));
                                    end
                                end
                            end
                        end else begin
                            res.line_status = ST_BAD_SUM;
                            n_err = r_err + 32'd1;
                        end
                    end else begin
                        res.line_status = ST_BAD_SUM;
                        n_err = r_err + 32'd1;
                    end
                end
                res.accepted_total       = n_acc;
                res.checksum_error_total = n_err;
            end
        end else if (eff_len < LEN_MAX) begin
            n_len = eff_len + 1'b1;
            if (eff_len == '0) begin
                // first byte of a new line
                n_dollar = (i_byte == CH_DOLLAR);
                n_star   = 1'b0;
                n_sum    = 8'd0;
                n_cas    = 2'd0;
                n_hex1   = 5'd0;
                n_hex2   = 5'd0;
                n_pos    = NAME_POS_FIRST;
                n_flags  = 4'hF;
                n_closed = 1'b0;
            end else begin
                // checksum and hex digits
                if (!r_star) begin
                    if (i_byte == CH_STAR) n_star = 1'b1;
                    else                   n_sum  = r_sum ^ i_byte;
                end else begin
                    if (r_cas == 2'd0) n_hex1 = hex_digit(i_byte);
                    if (r_cas == 2'd1) n_hex2 = hex_digit(i_byte);
                    if (r_cas != 2'd2) n_cas  = r_cas + 2'd1;
                end
                // sentence name
                if (!r_closed) begin
                    if (i_byte == CH_COMMA || i_byte == CH_STAR) begin
                        n_closed = 1'b1;
                    end else begin
                        if (r_pos >= NAME_POS_FIRST && r_pos <= NAME_POS_LAST) begin
                            for (int k = 0; k < 4; k++) begin
                                if (name_char(2'(k), r_pos) != i_byte) n_flags[k] = 1'b0;
                            end
                        end
                        if (r_pos != NAME_POS_SAT) n_pos = r_pos + 3'd1;
                    end
                end
            end
        end else begin
            // overlong line: drop and restart empty
            n_len = '0;
        end
    end

    // State registers, updated per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_dollar <= 1'b0;
            r_star   <= 1'b0;
            r_sum    <= 8'd0;
            r_cas    <= 2'd0;
            r_hex1   <= 5'd0;
            r_hex2   <= 5'd0;
            r_pos    <= 3'd0;
            r_flags  <= 4'hF;
            r_closed <= 1'b0;
            r_acc    <= 32'd0;
            r_err    <= 32'd0;
        end else if (i_fire) begin
            r_len    <= n_len;
            r_dollar <= n_dollar;
            r_star   <= n_star;
            r_sum    <= n_sum;
            r_cas    <= n_cas;
            r_hex1   <= n_hex1;
            r_hex2   <= n_hex2;
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_closed <= n_closed;
            r_acc    <= n_acc;
            r_err    <= n_err;
        end
    end

    assign o_res_valid = i_fire & res_valid;
    assign o_res       = res;

endmodule

@@ hdl/nsc_result_buf.sv @@
// ----------------------------------------------------------------------------
// nsc_result_buf
// Two-entry result buffer: output register plus skid register, so the input
// ready comes from a flop and never from the receiver's ready.
// ----------------------------------------------------------------------------
module nsc_result_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nsc_pkg::t_result i_res,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output nsc_pkg::t_result o_res
);
    import nsc_pkg::*;

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;
    logic    pop;

    assign pop = r_main_v & i_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v)    r_skid_v <= 1'b0;
            else if (!i_push) r_main_v <= 1'b0;
        end else if (i_push) begin
            if (r_main_v) r_skid_v <= 1'b1;
            else          r_main_v <= 1'b1;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_v)    r_main <= r_skid;
            else if (i_push) r_main <= i_res;
        end else if (i_push) begin
            if (r_main_v) r_skid <= i_res;
            else          r_main <= i_res;
        end
    end

    assign o_space = ~r_skid_v;
    assign o_valid = r_main_v;
    assign o_res   = r_main;

endmodule

@@ hdl/nmea_sentence_checksum_framer.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer
// NMEA 0183 line framer with checksum check and sentence type detection.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one received
//   character per transaction. CR is ignored, '$' restarts the line, and a
//   line reaching LINE_LIMIT bytes is dropped and restarts empty.
//   Result channel (o_res_valid / i_res_ready) carries one transaction for
//   each LF that ends a non-empty line: status, sentence kind, both checksums
//   and the running accepted / error totals.
//   Throughput: one byte per clock cycle while o_rx_ready is high, set by
//   the single register stage of line state; every byte's update is one
//   short combinational step. Results leave from the registered buffer.
//   Stall: results queue in an output register plus a skid register; bytes
//   keep flowing while one result waits, and o_rx_ready drops only when both
//   are full, driven from a register.
//   Reset: synchronous, active low; clears line state, both totals and any
//   pending results.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_framer #(
    parameter int LINE_LIMIT = nsc_pkg::LINE_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_line_status,
    output logic [2:0]  o_sentence_kind,
    output logic [7:0]  o_computed_checksum,
    output logic [7:0]  o_received_checksum,
    output logic [31:0] o_accepted_total,
    output logic [31:0] o_checksum_error_total
);
    import nsc_pkg::*;

    logic    rx_fire;
    logic    res_push;
    t_result res_new;
    t_result res_out;

    assign rx_fire = i_rx_valid & o_rx_ready;

    nsc_line_tracker #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (rx_fire),
        .i_byte      (i_rx_byte),
        .o_res_valid (res_push),
        .o_res       (res_new)
    );

    nsc_result_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_new),
        .o_space (o_rx_ready),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_res   (res_out)
    );

    assign o_line_status          = res_out.line_status;
    assign o_sentence_kind        = res_out.sentence_kind;
    assign o_computed_checksum    = res_out.computed_checksum;
    assign o_received_checksum    = res_out.received_checksum;
    assign o_accepted_total       = res_out.accepted_total;
    assign o_checksum_error_total = res_out.checksum_error_total;

`ifndef SYNTH
    // Input stalls only when two results are already waiting
    a_ready_implies_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> o_res_valid)
        else $error("input stalled with no pending result");

    // A new result only follows an accepted line feed
    a_result_after_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(rx_fire && i_rx_byte == CH_LF))
        else $error("result without line feed");

    // Lines without a leading dollar carry no checksums and no kind
    a_no_dollar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_line_status == ST_NO_DOLLAR) |->
        (o_computed_checksum == 8'd0 && o_received_checksum == 8'd0 &&
         o_sentence_kind == KIND_OTHER))
        else $error("no-dollar result carries data");

    // Only accepted lines name a sentence kind
    a_kind_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_sentence_kind != KIND_OTHER) |-> o_line_status == ST_ACCEPTED)
        else $error("sentence kind on rejected line");
`endif

endmodule
